/* hdl/utf8_sanitizer_defines.svh */
// Assertion macros shared by the utf8_sanitizer RTL.
// Expects clk and rst in the including module's scope.
`ifndef UTF8_SANITIZER_DEFINES_SVH
`define UTF8_SANITIZER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Clocked check, idle while reset is high
`define UTF8S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset
`define UTF8S_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTF8S_ASSERT(lbl, prop, msg)
`define UTF8S_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/utf8s_pkg.sv */
// Shared types and constants for the UTF-8 sanitizer.
// No dependencies.
package utf8s_pkg;

  // Replacement character U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Command queue between judge and output stages
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // One judged sequence: up to four bytes, oldest in bytes[0]
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;  // byte count minus one
    logic            last;    // final sequence caused by this input byte
    logic            done;    // final sequence of the text
  } cmd_t;

  typedef enum logic {
    FS_IDLE,
    FS_JUDGE
  } fsm_t;

endpackage

/* hdl/utf8s_front.sv */
// Front stage: accepts input bytes, keeps the pending window and judges
// one sequence per cycle into commands unless q_full. Needs utf8s_pkg.
module utf8s_front import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // text_end
  output logic       push,
  output cmd_t       cmd,
  input  logic       q_full
);

  `include "utf8_sanitizer_defines.svh"

  // Sequence length from a lead byte; zero for a byte that cannot lead
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    if (b <= 8'h7F)                    r = 3'd1;
    else if (b >= 8'hC2 && b <= 8'hDF) r = 3'd2;
    else if (b >= 8'hE0 && b <= 8'hEF) r = 3'd3;
    else if (b >= 8'hF0 && b <= 8'hF4) r = 3'd4;
    return r;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & 8'hC0) == 8'h80;
  endfunction

  function automatic logic seq_ok(input logic [3:0][7:0] w, input logic [2:0] len);
    logic r;
    r = 1'b0;
    unique case (len)
      3'd1: r = 1'b1;
      3'd2: r = is_cont(w[1]);
      3'd3: r = is_cont(w[1]) && is_cont(w[2])
                && (w[0] != 8'hE0 || w[1] >= 8'hA0)
                && (w[0] != 8'hED || w[1] <= 8'h9F);
      3'd4: r = is_cont(w[1]) && is_cont(w[2]) && is_cont(w[3])
                && (w[0] != 8'hF0 || w[1] >= 8'h90)
                && (w[0] != 8'hF4 || w[1] <= 8'h8F);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  fsm_t            state, state_next;
  logic [3:0][7:0] win;
  logic [2:0]      n;
  logic            at_end;

  logic [2:0]      len, adv, n_after, len2;
  logic            incomplete, stop, ok, last;
  logic [31:0]     shifted;

  // Judge the sequence at the head of the window
  always_comb begin
    len        = lead_len(win[0]);
    incomplete = (len != 3'd0) && (len > n);
    stop       = incomplete && !at_end;
    ok         = (len != 3'd0) && !incomplete && seq_ok(win, len);
    adv        = ok ? len : 3'd1;
    n_after    = n - adv;
    shifted    = win >> {adv, 3'b000};
    len2       = lead_len(shifted[7:0]);
    // Look ahead: does the next judgment stall or run out of bytes
    last       = (n_after == 3'd0) ||
                 (!at_end && (len2 != 3'd0) && (len2 > n_after));
  end

  // Build the command
  always_comb begin
    if (ok) begin
      cmd.bytes  = win;
      cmd.cnt_m1 = 2'(len - 3'd1);
    end else begin
      cmd.bytes  = {8'h00, REPL_B2, REPL_B1, REPL_B0};
      cmd.cnt_m1 = 2'd2;
    end
    cmd.last = last;
    cmd.done = last && at_end;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE: begin
        if (s_tvalid) state_next = FS_JUDGE;
      end
      FS_JUDGE: begin
        if (stop || (!q_full && last)) state_next = FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    unique case (state)
      FS_IDLE:  s_tready = 1'b1;
      FS_JUDGE: push     = !stop && !q_full;
      default: begin
        s_tready = 1'b0;
        push     = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      n     <= 3'd0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) n <= n + 3'd1;
      else if (push)            n <= n_after;
    end
  end

  // Window bytes: append on transfer, drop judged bytes on push
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      win[n[1:0]] <= s_tdata;
      at_end      <= s_tlast;
    end else if (push) begin
      win <= shifted;
    end
  end

  `UTF8S_ASSERT(a_judge_has_bytes, (state == FS_JUDGE) |-> (n != 3'd0), "judging an empty window")
  `UTF8S_ASSERT(a_idle_pending_le3, (state == FS_IDLE) |-> (n <= 3'd3), "more than three pending bytes")
  `UTF8S_ASSERT(a_flush_at_end, (push && cmd.done) |=> (n == 3'd0), "bytes left after end of text")

endmodule

/* hdl/utf8s_queue.sv */
// Short command queue between the judge and output stages.
// Depends on utf8s_pkg.
module utf8s_queue import utf8s_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t head,
  input  logic pop
);

  `include "utf8_sanitizer_defines.svh"

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign head    = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Store incoming command
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  `UTF8S_ASSERT(a_no_overflow, !(push && full), "push into full queue")
  `UTF8S_ASSERT(a_no_underflow, !(pop && !q_valid), "pop from empty queue")

endmodule

/* hdl/utf8s_back.sv */
// Output stage: expands queued commands into one byte per transfer,
// holding each byte in an output register. Depends on utf8s_pkg.
module utf8s_back import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // run_last
  output logic       m_tlast    // text_done
);

  `include "utf8_sanitizer_defines.svh"

  logic [1:0] idx;
  logic       load, final_byte;

  assign load       = q_valid && (!m_tvalid || m_tready);
  assign final_byte = (idx == head.cnt_m1);
  assign pop        = load && final_byte;

  // Valid flag and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= final_byte ? 2'd0 : idx + 2'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load next byte with its flags
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= head.bytes[idx];
      m_tuser <= final_byte && head.last;
      m_tlast <= final_byte && head.done;
    end
  end

  `UTF8S_ASSERT(a_idx_in_range, q_valid |-> (idx <= head.cnt_m1), "byte index past command")
  `UTF8S_ASSERT(a_idx_rest, !q_valid |-> (idx == 2'd0), "byte index not at start")

endmodule

/* hdl/utf8_sanitizer.sv */
// Top level of the UTF-8 sanitizer: judge front end, command queue and
// byte output stage. Depends on utf8s_pkg, utf8s_front, utf8s_queue, utf8s_back.

// Bytes of a text enter one per transfer, s_tlast on the last byte. Valid
// UTF-8 sequences leave unchanged; a bad or truncated lead byte leaves as
// EF BF BD and judging resumes at the following byte. Up to three bytes
// of an unfinished sequence stay pending until it completes or the text
// ends; an input byte may therefore cause no output at all. m_tuser marks
// the last output byte caused by an input byte, m_tlast the final byte
// of the text. The front end takes a byte, then judges the sequences
// from it (one to four) into commands, holding while the queue is full,
// or judges nothing while the sequence is still incomplete; it does not
// take a new byte during judging. A two-entry command queue then feeds
// the output register, which sends one byte per cycle unless m_tready is
// low or the queue is empty. A replaced byte leaves as three bytes
// through the single-byte output port.
module utf8_sanitizer import utf8s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // text_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // run_last
  output logic       m_tlast    // text_done
);

  logic push, q_full, q_valid, pop;
  cmd_t cmd, head;

  utf8s_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .push     (push),
    .cmd      (cmd),
    .q_full   (q_full)
  );

  utf8s_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_cmd  (cmd),
    .full    (q_full),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop)
  );

  utf8s_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for utf8_sanitizer: random texts in, sanitized bytes out.
// Depends on utf8s_pkg and the utf8_sanitizer RTL; reads no files.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8s_pkg::*;

  // UTF-8 byte classes and lead-specific bounds on the second byte
  localparam logic [7:0] ASCII_HI   = 8'h7F;
  localparam logic [7:0] CONT_LO    = 8'h80;
  localparam logic [7:0] CONT_HI    = 8'hBF;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] SURR_LEAD  = 8'hED;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] E0_NEXT_LO = 8'hA0;
  localparam logic [7:0] ED_NEXT_HI = 8'h9F;
  localparam logic [7:0] F0_NEXT_LO = 8'h90;
  localparam logic [7:0] F4_NEXT_HI = 8'h8F;

  localparam int RESET_CYCLES = 11;
  localparam int RAND_ITEMS   = 240;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_done;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       s_tlast = 1'b0;    // text_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tuser;           // run_last
  logic       m_tlast;           // text_done

  text_byte_t text_q[$];
  out_beat_t  sanitized_q[$];
  logic [7:0] held_bytes [3];
  int         held_cnt;
  int         err_cnt;
  int         send_gap;
  int         recv_stall;
  int         quiet_cycles;
  bit         send_calm;
  bit         recv_calm;

  utf8_sanitizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic fin);
    text_q.push_back(text_byte_t'{data: b, last: fin});
  endfunction

  // Length a lead byte announces; zero for a byte that cannot start a sequence
  function automatic int lead_len(input logic [7:0] b);
    if (b <= ASCII_HI) return 1;
    if (b >= LEAD2_LO && b <= LEAD2_HI) return 2;
    if (b >= LEAD3_LO && b <= LEAD3_HI) return 3;
    if (b >= LEAD4_LO && b <= LEAD4_HI) return 4;
    return 0;
  endfunction

  function automatic bit is_cont(input logic [7:0] b);
    return b >= CONT_LO && b <= CONT_HI;
  endfunction

  // Judge a complete sequence held in seg[0..len-1]
  function automatic bit seq_fine(input logic [3:0][7:0] seg, input int len);
    case (len)
      1: return 1'b1;
      2: return is_cont(seg[1]);
      3: return is_cont(seg[1]) && is_cont(seg[2])
             && (seg[0] != LEAD3_LO || seg[1] >= E0_NEXT_LO)
             && (seg[0] != SURR_LEAD || seg[1] <= ED_NEXT_HI);
      4: return is_cont(seg[1]) && is_cont(seg[2]) && is_cont(seg[3])
             && (seg[0] != LEAD4_LO || seg[1] >= F0_NEXT_LO)
             && (seg[0] != LEAD4_HI || seg[1] <= F4_NEXT_HI);
      default: return 1'b0;
    endcase
  endfunction

  function automatic void expect_beat(input logic [7:0] b);
    sanitized_q.push_back(out_beat_t'{data: b, run_last: 1'b0, text_done: 1'b0});
  endfunction

  // Work out the bytes one accepted input causes and advance the held window
  function automatic void predict_sanitized(input logic [7:0] b, input logic fin);
    logic [3:0][7:0] win;
    logic [3:0][7:0] seg;
    int n, pos, len, k, first;
    first = sanitized_q.size();
    win = '0;
    n = held_cnt;
    for (k = 0; k < n; k++) win[k] = held_bytes[k];
    win[n] = b;
    n++;
    pos = 0;
    while (pos < n) begin
      len = lead_len(win[pos]);
      if (len != 0 && pos + len > n) begin
        if (!fin) break;
        len = 0;
      end
      seg = win >> (pos * 8);
      if (len != 0 && seq_fine(seg, len)) begin
        for (k = 0; k < len; k++) expect_beat(seg[k]);
        pos += len;
      end else begin
        expect_beat(REPL_B0);
        expect_beat(REPL_B1);
        expect_beat(REPL_B2);
        pos++;
      end
    end
    held_cnt = n - pos;
    for (k = 0; k < held_cnt; k++) held_bytes[k] = win[pos + k];
    if (sanitized_q.size() > first) begin
      sanitized_q[sanitized_q.size() - 1].run_last = 1'b1;
      sanitized_q[sanitized_q.size() - 1].text_done = fin;
    end
  endfunction

  // Build a multi-byte sequence; broken ones violate a lead, second-byte or continuation bound
  function automatic logic [3:0][7:0] make_seq(input int len, input bit broken);
    logic [3:0][7:0] s;
    int pick, k;
    pick = $urandom_range(0, 2);
    for (k = 0; k < 4; k++) s[k] = 8'($urandom_range(CONT_LO, CONT_HI));
    case (len)
      2: begin
        if (broken) s[0] = 8'($urandom_range(8'hC0, 8'hC1));
        else s[0] = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
      end
      3: begin
        case (pick)
          0: begin
            s[0] = LEAD3_LO;
            if (broken) s[1] = 8'($urandom_range(CONT_LO, E0_NEXT_LO - 1));
            else s[1] = 8'($urandom_range(E0_NEXT_LO, CONT_HI));
          end
          1: begin
            s[0] = SURR_LEAD;
            if (broken) s[1] = 8'($urandom_range(ED_NEXT_HI + 1, CONT_HI));
            else s[1] = 8'($urandom_range(CONT_LO, ED_NEXT_HI));
          end
          default: begin
            s[0] = 8'($urandom_range(LEAD3_LO + 1, LEAD3_HI));
            if (s[0] == SURR_LEAD) s[0] = SURR_LEAD - 1;
            if (broken) s[2] = 8'($urandom_range(0, ASCII_HI));
          end
        endcase
      end
      default: begin
        case (pick)
          0: begin
            s[0] = LEAD4_LO;
            if (broken) s[1] = 8'($urandom_range(CONT_LO, F0_NEXT_LO - 1));
            else s[1] = 8'($urandom_range(F0_NEXT_LO, CONT_HI));
          end
          1: begin
            s[0] = LEAD4_HI;
            if (broken) s[1] = 8'($urandom_range(F4_NEXT_HI + 1, CONT_HI));
            else s[1] = 8'($urandom_range(CONT_LO, F4_NEXT_HI));
          end
          default: begin
            if (broken) s[0] = 8'($urandom_range(LEAD4_HI + 1, 8'hFF));
            else s[0] = 8'($urandom_range(LEAD4_LO + 1, LEAD4_HI - 1));
          end
        endcase
      end
    endcase
    return s;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int idle_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Drive input transfers from the pending text queue
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
      send_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if ($urandom_range(0, 39) == 0) send_calm <= ~send_calm;
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (text_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= text_q[0].data;
        s_tlast  <= text_q[0].last;
        void'(text_q.pop_front());
        send_gap <= idle_len(send_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the output side at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (m_tvalid && m_tready) begin
        if ($urandom_range(0, 39) == 0) recv_calm <= ~recv_calm;
        recv_stall <= idle_len(recv_calm);
      end
    end
  end

  // Predict on input transfers, check output transfers, watch for a hang
  always @(posedge clk) begin : monitor
    out_beat_t want;
    bit in_fire, out_fire;
    in_fire  = s_tvalid && s_tready;
    out_fire = m_tvalid && m_tready;
    if (rst) begin
      held_cnt     = 0;
      quiet_cycles <= 0;
    end else begin
      if (in_fire) predict_sanitized(s_tdata, s_tlast);
      if (out_fire) begin
        if (sanitized_q.size() == 0) begin
          flag_error($sformatf("unexpected output byte %h", m_tdata));
        end else begin
          want = sanitized_q.pop_front();
          if (m_tdata !== want.data)
            flag_error($sformatf("out_byte %h, expected %h", m_tdata, want.data));
          if (m_tuser !== want.run_last)
            flag_error($sformatf("run_last %b, expected %b on byte %h",
                                 m_tuser, want.run_last, want.data));
          if (m_tlast !== want.text_done)
            flag_error($sformatf("text_done %b, expected %b on byte %h",
                                 m_tlast, want.text_done, want.data));
        end
      end
      if (in_fire || out_fire) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
        $display("utf8_sanitizer verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0]      txt[$];
    logic [3:0][7:0] s;
    int nseg, kind, len, cut, k, rand_items;
    err_cnt   = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;

    // Directed: ASCII extremes, valid 2- and 4-byte, stray continuation,
    // bad leads, overlong 3-byte, surrogate, above U+10FFFF (twelve bytes
    // out of one input) and a sequence cut short by the end of the text
    add_byte(8'h00, 1'b0); add_byte(8'h7F, 1'b0);
    add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hDF, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'h80, 1'b0); add_byte(8'hC0, 1'b0); add_byte(8'hF5, 1'b0);
    add_byte(8'hE0, 1'b0); add_byte(8'h9F, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hED, 1'b0); add_byte(8'hA0, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hF4, 1'b0); add_byte(8'h90, 1'b0);
    add_byte(8'h80, 1'b0); add_byte(8'hBF, 1'b0);
    add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0);
    add_byte(8'h80, 1'b0); add_byte(8'h80, 1'b0);
    add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b1);
    add_byte(8'hFF, 1'b1);

    // Random texts: mostly well-formed sequences, some noise and broken ones
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      txt.delete();
      nseg = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 5);
      repeat (nseg) begin
        kind = $urandom_range(0, 99);
        len  = $urandom_range(2, 4);
        if (kind < 22) begin
          txt.push_back(8'($urandom_range(0, ASCII_HI)));
        end else if (kind < 70) begin
          s = make_seq(len, 1'b0);
          for (k = 0; k < len; k++) txt.push_back(s[k]);
        end else if (kind < 80) begin
          txt.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 90) begin
          s = make_seq(len, 1'b0);
          cut = $urandom_range(1, len - 1);
          for (k = 0; k < cut; k++) txt.push_back(s[k]);
        end else begin
          s = make_seq(len, 1'b1);
          for (k = 0; k < len; k++) txt.push_back(s[k]);
        end
      end
      for (k = 0; k < txt.size(); k++) add_byte(txt[k], k == txt.size() - 1);
      rand_items += txt.size();
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Drain input, then the outstanding results, then let the pipe settle
    while (text_q.size() != 0 || s_tvalid) @(posedge clk);
    while (sanitized_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("utf8_sanitizer verification clean");
    end else begin
      $display("utf8_sanitizer verification failed");
    end
    $finish;
  end

endmodule
